[design/java_lcg_random_generator_assert.svh]
// Assertion macros used by the generator top level.
`ifndef JAVA_LCG_RANDOM_GENERATOR_ASSERT_SVH
`define JAVA_LCG_RANDOM_GENERATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JLCG_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JLCG_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/jlcg_pkg.sv]
// Package with constants and payload types of the 48-bit LCG generator.
`default_nettype none

package jlcg_pkg;

  localparam logic [47:0] LCG_MULT = 48'h0005_DEEC_E66D;
  localparam logic [47:0] LCG_ADD  = 48'd11;

  // The multiplier constant padded to a whole number of 2-bit digits.
  localparam int unsigned MUL_DIGIT_W = 2;
  localparam int unsigned MUL_STEPS   = 18;
  localparam logic [MUL_DIGIT_W*MUL_STEPS-1:0] LCG_MULT_PAD = 36'h5_DEEC_E66D;

  localparam int unsigned DIV_STEPS = 31;

  localparam logic [1:0] OP_INT    = 2'd0;
  localparam logic [1:0] OP_DOUBLE = 2'd1;
  localparam logic [1:0] OP_PAIR   = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  operation;
    logic [30:0] bound;
  } in_item_t;

  typedef struct packed {
    logic [52:0] value;
    logic        ok;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

[design/jlcg_mul.sv]
// Iterative LCG step unit: state * multiplier + increment, two multiplier bits a cycle.
`default_nettype none

module jlcg_mul (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [47:0] state_i,
  output logic        done_o,
  output logic [47:0] result_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [47:0] sh_q;
  logic [47:0] acc_q;
  logic [1:0]  digit;
  logic [47:0] acc_d;

  assign digit = jlcg_pkg::LCG_MULT_PAD[{cnt_q, 1'b0} +: 2];
  assign acc_d = acc_q + ({48{digit[0]}} & sh_q) + ({48{digit[1]}} & {sh_q[46:0], 1'b0});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(jlcg_pkg::MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Product bits above 47 fall away, which gives the modulo 2^48 for free.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      sh_q  <= state_i;
      acc_q <= jlcg_pkg::LCG_ADD;
    end else if (busy_q) begin
      sh_q  <= {sh_q[45:0], 2'b00};
      acc_q <= acc_d;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

`default_nettype wire

[design/jlcg_div.sv]
// Restoring remainder unit for a 31-bit draw and a 31-bit bound, one bit a cycle.
`default_nettype none

module jlcg_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [30:0] dividend_i,
  input  logic [30:0] divisor_i,
  output logic        done_o,
  output logic [30:0] rem_o
);

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [30:0] dvd_q;
  logic [30:0] rem_q;
  logic [31:0] trial;
  logic        ge;
  logic [31:0] diff;
  logic [30:0] rem_d;

  assign trial = {rem_q, dvd_q[30]};
  assign ge    = trial >= {1'b0, divisor_i};
  assign diff  = trial - {1'b0, divisor_i};
  // The partial remainder always stays below the divisor, so 31 bits hold it.
  assign rem_d = ge ? diff[30:0] : trial[30:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'(jlcg_pkg::DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[29:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

endmodule

`default_nettype wire

[design/java_lcg_random_generator.sv]
// Top level of the 48-bit LCG random generator, bit-exact with the common library generator.
// Each state step runs on an iterative multiplier; a draw below a power-of-two bound
// then takes a 31x31 product in the power-of-two state, and any other bound a remainder
// pass plus a check, with a new state step and remainder pass whenever the draw is
// rejected. A pair draws two integers and a double takes two state steps. A zero bound
// on an integer or pair item, or an unused operation code, yields one result with ok low.
// The input is stalled for the whole of an item; the result register lets the next
// item in while the last result still waits. Writing the seed reloads the state, but a
// state step that finishes together with the write takes precedence.
`default_nettype none

`include "java_lcg_random_generator_assert.svh"

module java_lcg_random_generator (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                seed_we_i,
  input  logic signed [31:0]  seed_wdata_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  jlcg_pkg::in_item_t  in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output jlcg_pkg::out_item_t out_data_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_POW,
    S_DIV,
    S_EMIT
  } state_e;

  state_e              state_q;
  logic [47:0]         lcg_q;
  logic [1:0]          op_q;
  logic [30:0]         bound_q;
  logic                pow2_q;
  logic                pair_first_q;
  logic                dbl_lo_q;
  logic [25:0]         hi_q;
  logic [30:0]         bits_q;
  logic [52:0]         res_q;
  logic                ok_q;
  logic                last_q;
  logic                step_go_q;
  logic                div_go_q;
  logic                out_valid_q;
  jlcg_pkg::out_item_t out_q;

  logic        step_done;
  logic [47:0] step_res;
  logic        div_done;
  logic [30:0] div_rem;
  logic [61:0] pow_prod;
  logic [32:0] chk;
  logic        reject;
  logic        in_pow2;
  logic [47:0] seed_state;

  jlcg_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (step_go_q),
    .state_i  (lcg_q),
    .done_o   (step_done),
    .result_o (step_res)
  );

  jlcg_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_go_q),
    .dividend_i (bits_q),
    .divisor_i  (bound_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  assign seed_state = {{16{seed_wdata_i[31]}}, seed_wdata_i} ^ jlcg_pkg::LCG_MULT;
  assign in_pow2    = (in_data_i.bound & (in_data_i.bound - 31'd1)) == 31'd0;
  assign pow_prod   = {31'd0, bound_q} * {31'd0, bits_q};

  // A draw is rejected when draw - remainder + bound - 1 reaches 2^31.
  assign chk    = {2'b00, bits_q} - {2'b00, div_rem} + {2'b00, bound_q} - 33'd1;
  assign reject = chk[32] | chk[31];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      lcg_q        <= jlcg_pkg::LCG_MULT;
      pair_first_q <= 1'b0;
      dbl_lo_q     <= 1'b0;
      step_go_q    <= 1'b0;
      div_go_q     <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      step_go_q <= 1'b0;
      div_go_q  <= 1'b0;
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (seed_we_i) begin
        lcg_q <= seed_state;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            op_q         <= in_data_i.operation;
            bound_q      <= in_data_i.bound;
            pow2_q       <= in_pow2;
            pair_first_q <= in_data_i.operation == jlcg_pkg::OP_PAIR;
            dbl_lo_q     <= 1'b0;
            if (in_data_i.operation == jlcg_pkg::OP_DOUBLE) begin
              step_go_q <= 1'b1;
              state_q   <= S_STEP;
            end else if (in_data_i.operation == jlcg_pkg::OP_UNUSED ||
                         in_data_i.bound == 31'd0) begin
              res_q   <= '0;
              ok_q    <= 1'b0;
              last_q  <= 1'b1;
              state_q <= S_EMIT;
            end else begin
              step_go_q <= 1'b1;
              state_q   <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (step_done) begin
            lcg_q <= step_res;
            if (op_q == jlcg_pkg::OP_DOUBLE) begin
              if (!dbl_lo_q) begin
                hi_q      <= step_res[47:22];
                dbl_lo_q  <= 1'b1;
                step_go_q <= 1'b1;
              end else begin
                res_q   <= {hi_q, step_res[47:21]};
                ok_q    <= 1'b1;
                last_q  <= 1'b1;
                state_q <= S_EMIT;
              end
            end else begin
              bits_q <= step_res[47:17];
              if (pow2_q) begin
                state_q <= S_POW;
              end else begin
                div_go_q <= 1'b1;
                state_q  <= S_DIV;
              end
            end
          end
        end
        S_POW: begin
          res_q   <= {22'd0, pow_prod[61:31]};
          ok_q    <= 1'b1;
          last_q  <= !pair_first_q;
          state_q <= S_EMIT;
        end
        S_DIV: begin
          if (div_done) begin
            if (reject) begin
              step_go_q <= 1'b1;
              state_q   <= S_STEP;
            end else begin
              res_q   <= {22'd0, div_rem};
              ok_q    <= 1'b1;
              last_q  <= !pair_first_q;
              state_q <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            out_q.value <= res_q;
            out_q.ok    <= ok_q;
            out_q.last  <= last_q;
            if (last_q) begin
              state_q <= S_IDLE;
            end else begin
              // The first result of a pair is out; draw the second one.
              pair_first_q <= 1'b0;
              step_go_q    <= 1'b1;
              state_q      <= S_STEP;
            end
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `JLCG_ASSERT_IMP(a_step_done_in_step, clk_i, rst_ni, step_done, state_q == S_STEP, "step unit finished outside the step state")
  `JLCG_ASSERT_IMP(a_div_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV, "remainder unit finished outside the division state")
  `JLCG_ASSERT_IMP(a_fail_is_zero, clk_i, rst_ni, out_valid_o && !out_data_o.ok, out_data_o.value == 53'd0 && out_data_o.last, "failed result not zero or not final")
  `JLCG_ASSERT_IMP(a_first_is_ok, clk_i, rst_ni, out_valid_o && !out_data_o.last, out_data_o.ok && out_data_o.value[52:31] == 22'd0, "first pair result not a valid integer")
  `JLCG_ASSERT_NXT(a_go_starts_unit, clk_i, rst_ni, step_go_q, !step_done && state_q == S_STEP, "step start did not hold the step state")

endmodule

`default_nettype wire
